>>> design/arp_cache_table_core_assert.svh
// Assertion macros shared by the checker of the address-resolution cache.
// Stand-alone header; included by files that write concurrent assertions.
`ifndef ARP_CACHE_TABLE_CORE_ASSERT_SVH
`define ARP_CACHE_TABLE_CORE_ASSERT_SVH

// Generic form: explicit clock and active-low reset.
`define ARPCT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Usual form: the block's own clock and reset names.
`define ARPCT_ASSERT(lbl, prop, msg) \
  `ARPCT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> design/arpct_pkg.sv
// Shared types and constants of the address-resolution cache.
// No dependencies; every other design file but the assertion header refers to it by scoped names.
package arpct_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_INSERT = 1'b1
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic             hit;
    logic [MAC_W-1:0] mac;
  } tok_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic wr_en;
    logic entry_valid;
  } cell_ctl_t;

endpackage

>>> design/arpct_if.sv
// Valid/ready channel interfaces for requests and responses of the cache.
// Depends on arpct_pkg for field widths.
interface arpct_req_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [arpct_pkg::IP_W-1:0]   ip_addr;
  logic [arpct_pkg::MAC_W-1:0]  mac_addr;

  modport source (output valid, func, ip_addr, mac_addr, input ready);
  modport sink   (input valid, func, ip_addr, mac_addr, output ready);
endinterface

interface arpct_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [arpct_pkg::MAC_W-1:0]  mac_found;

  modport source (output valid, hit, mac_found, input ready);
  modport sink   (input valid, hit, mac_found, output ready);
endinterface

>>> design/arpct_cell.sv
// One table entry with its stage of the search chain.
// Depends on arpct_pkg for the token and control types.
module arpct_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  arpct_pkg::cell_ctl_t          ctl_i,
  input  logic [arpct_pkg::IP_W-1:0]    wr_ip_i,
  input  logic [arpct_pkg::MAC_W-1:0]   wr_mac_i,
  input  logic                          tok_valid_i,
  input  arpct_pkg::tok_t               tok_i,
  output logic                          tok_valid_o,
  output arpct_pkg::tok_t               tok_o
);

  logic [arpct_pkg::IP_W-1:0]  ip_q;
  logic [arpct_pkg::MAC_W-1:0] mac_q;
  logic                        tok_valid_q;
  arpct_pkg::tok_t             tok_q;
  arpct_pkg::tok_t             tok_d;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      ip_q  <= wr_ip_i;
      mac_q <= wr_mac_i;
    end
  end

  // An earlier hit is passed on untouched, so the lowest index wins.
  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit && ctl_i.entry_valid && (ip_q == tok_i.ip)) begin
      tok_d.hit = 1'b1;
      tok_d.mac = mac_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_valid_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

>>> design/arp_cache_table_core.sv
// Top level of the address-resolution cache: request/response handshake,
// fill pointer and the chain of entry cells. Depends on arpct_pkg, arpct_if
// and arpct_cell.
//
// A small cache mapping IPv4 addresses to 48-bit MAC addresses, ENTRIES
// deep (16 by default), with round-robin replacement. Each request gives
// exactly one response. An insert writes the pair at the fill pointer
// without looking for duplicates and answers with hit clear and a zero MAC
// in the following cycle. A lookup sends a search token down a row of
// ENTRIES cells, one cell per cycle; each cell holds one entry and compares
// it with the address, and the first valid match sets hit and takes that
// cell's MAC, so the lowest-index copy of a duplicated address wins. Before
// the pointer first wraps, only the entries below it are valid; afterwards
// all are. A lookup therefore passes from acceptance to response through
// the request register, each cell in turn and the response register. The
// block works on one request at a time and takes the next one as soon as
// the previous response is either taken or about to be; a pending response
// is held in an output register while the downstream side stalls. After
// reset the table is empty and no clearing pass is needed.
module arp_cache_table_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  arpct_req_if.sink         req_i,
  arpct_rsp_if.source       rsp_o
);

  arpct_pkg::state_e                 state_q;
  arpct_pkg::state_e                 state_d;
  logic [arpct_pkg::IDX_W-1:0]       fill_q;
  logic                              full_q;
  logic                              head_valid_q;
  arpct_pkg::tok_t                   head_q;
  logic                              out_valid_q;
  logic                              out_hit_q;
  logic [arpct_pkg::MAC_W-1:0]       out_mac_q;

  logic                              req_ready;
  logic                              req_accept;
  logic                              is_insert;
  logic                              out_load;

  logic                              tok_valid [arpct_pkg::ENTRIES+1];
  arpct_pkg::tok_t                   tok       [arpct_pkg::ENTRIES+1];

  // A new request may be taken only when idle and when the response
  // register is free or is being emptied in this very cycle.
  assign req_ready  = (state_q == arpct_pkg::ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign req_accept = req_i.valid && req_ready;
  assign is_insert  = (req_i.func == arpct_pkg::FUNC_INSERT);

  // The search token leaving the last cell is the lookup result.
  assign out_load = (req_accept && is_insert) || tok_valid[arpct_pkg::ENTRIES];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      arpct_pkg::ST_IDLE: begin
        if (req_accept && !is_insert) begin
          state_d = arpct_pkg::ST_SEARCH;
        end
      end
      arpct_pkg::ST_SEARCH: begin
        if (tok_valid[arpct_pkg::ENTRIES]) begin
          state_d = arpct_pkg::ST_IDLE;
        end
      end
      default: state_d = arpct_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arpct_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Fill pointer and full flag: the pointer wraps after the last entry and
  // the full flag then stays set until reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      full_q <= 1'b0;
    end else if (req_accept && is_insert) begin
      if (fill_q == arpct_pkg::LAST_IDX) begin
        fill_q <= '0;
        full_q <= 1'b1;
      end else begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // The request register at the head of the chain starts a search with no
  // hit and a zero MAC, which is also the miss answer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
    end else begin
      head_valid_q <= req_accept && !is_insert;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept && !is_insert) begin
      head_q.ip  <= req_i.ip_addr;
      head_q.hit <= 1'b0;
      head_q.mac <= '0;
    end
  end

  assign tok_valid[0] = head_valid_q;
  assign tok[0]       = head_q;

  for (genvar g = 0; g < arpct_pkg::ENTRIES; g++) begin : g_cell
    arpct_pkg::cell_ctl_t ctl;

    // Inserts are never accepted while a search is running, so a cell's
    // entry is stable for the whole time the token passes it.
    assign ctl.wr_en       = req_accept && is_insert
                             && (fill_q == arpct_pkg::IDX_W'(g));
    assign ctl.entry_valid = full_q || (arpct_pkg::IDX_W'(g) < fill_q);

    arpct_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .wr_ip_i     (req_i.ip_addr),
      .wr_mac_i    (req_i.mac_addr),
      .tok_valid_i (tok_valid[g]),
      .tok_i       (tok[g]),
      .tok_valid_o (tok_valid[g+1]),
      .tok_o       (tok[g+1])
    );
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (req_accept && is_insert) begin
        out_hit_q <= 1'b0;
        out_mac_q <= '0;
      end else begin
        out_hit_q <= tok[arpct_pkg::ENTRIES].hit;
        out_mac_q <= tok[arpct_pkg::ENTRIES].mac;
      end
    end
  end

  assign req_i.ready     = req_ready;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.hit       = out_hit_q;
  assign rsp_o.mac_found = out_mac_q;

endmodule

>>> design/arpct_checker.sv
// Port-level checker of the address-resolution cache and its bind statement.
// Depends on arpct_pkg and arp_cache_table_core_assert.svh.
`include "arp_cache_table_core_assert.svh"

module arpct_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         req_func_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic                         rsp_hit_i,
  input logic [arpct_pkg::MAC_W-1:0]  rsp_mac_i
);

  // An accepted insert is answered in the next cycle, never as a hit.
  `ARPCT_ASSERT(a_insert_rsp, req_valid_i && req_ready_i && (req_func_i == arpct_pkg::FUNC_INSERT) |=> rsp_valid_i && !rsp_hit_i, "insert request not answered as a miss in the next cycle")

  // A lookup keeps the request side closed while the search runs.
  `ARPCT_ASSERT(a_lookup_busy, req_valid_i && req_ready_i && (req_func_i == arpct_pkg::FUNC_LOOKUP) |=> !req_ready_i, "request side open during a lookup")

  // A response without a hit carries a zero MAC.
  `ARPCT_ASSERT(a_miss_zero, rsp_valid_i && !rsp_hit_i |-> rsp_mac_i == '0, "miss response with a non-zero MAC")

  // A stalled response holds its payload.
  `ARPCT_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_mac_i) && $stable(rsp_hit_i), "stalled response changed")

endmodule

bind arp_cache_table_core arpct_checker u_arpct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_func_i  (req_i.func),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_hit_i   (rsp_o.hit),
  .rsp_mac_i   (rsp_o.mac_found)
);

>>> dv/arp_cache_table_core_checker.sv
// Checker for the address-resolution cache: watches both channels, predicts each response.
// It depends on arpct_pkg and on the channel interfaces in arpct_if.
module arp_cache_table_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  arpct_req_if        req,
  arpct_rsp_if        rsp,
  output int unsigned mismatch_count_o,
  output int unsigned answers_waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import arpct_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac_found;
  } arp_answer_t;

  logic [IP_W-1:0]  ip_tbl  [ENTRIES];
  logic [MAC_W-1:0] mac_tbl [ENTRIES];
  logic [IDX_W-1:0] fill_ptr;
  logic             table_full;
  arp_answer_t      pending_answers[$];

  // Applies one request to the shadow table and returns the response it should give.
  function automatic arp_answer_t resolve_request(func_e op, logic [IP_W-1:0] ip,
                                                  logic [MAC_W-1:0] mac);
    arp_answer_t ans;
    int unsigned span;
    ans  = '0;
    span = table_full ? ENTRIES : int'(fill_ptr);
    if (op == FUNC_LOOKUP) begin
      // Scanning downwards leaves the lowest matching index as the winner.
      for (int k = int'(span) - 1; k >= 0; k--) begin
        if (ip_tbl[k] == ip) begin
          ans.hit       = 1'b1;
          ans.mac_found = mac_tbl[k];
        end
      end
    end else begin
      ip_tbl[fill_ptr]  = ip;
      mac_tbl[fill_ptr] = mac;
      if (fill_ptr == LAST_IDX) begin
        table_full = 1'b1;
        fill_ptr   = '0;
      end else begin
        fill_ptr = fill_ptr + 1'b1;
      end
    end
    return ans;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    arp_answer_t exp_ans;
    if (!rst_ni) begin
      fill_ptr          = '0;
      table_full        = 1'b0;
      pending_answers.delete();
      mismatch_count_o  <= 0;
      answers_waiting_o <= 0;
    end else begin
      // The response side is checked first: a response and a new request may share an edge.
      if (rsp.valid && rsp.ready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected response, expected none, got hit %0b mac %012h",
                   $time, rsp.hit, rsp.mac_found);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          exp_ans = pending_answers.pop_front();
          if (rsp.hit !== exp_ans.hit || rsp.mac_found !== exp_ans.mac_found) begin
            $display("%0t: response mismatch, expected hit %0b mac %012h, got hit %0b mac %012h",
                     $time, exp_ans.hit, exp_ans.mac_found, rsp.hit, rsp.mac_found);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_answers.push_back(resolve_request(func_e'(req.func), req.ip_addr,
                                                  req.mac_addr));
      end
      answers_waiting_o <= pending_answers.size();
    end
  end

endmodule

>>> dv/arp_cache_table_core_tb.sv
// Top of the address-resolution cache testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. It depends on arpct_pkg, arpct_if and the checker.
module arp_cache_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arpct_pkg::*;

  // Cycles without any accepted request or response before the run is abandoned.
  // The longest deliberate hold-off below is LONG_HOLD_CYCLES, so this leaves ample room.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_REQUESTS = 400;
  localparam int unsigned LONG_HOLD_AT = 150;
  localparam int unsigned LONG_HOLD_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned mismatch_count;
  int unsigned answers_waiting;
  int unsigned idle_cycles;
  logic        sender_burst;
  logic        receiver_burst;

  // Addresses inserted recently; lookups draw on them so that most of them hit.
  logic [IP_W-1:0] known_ips[$];

  arpct_req_if req_if ();
  arpct_rsp_if rsp_if ();

  arp_cache_table_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  arp_cache_table_core_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req               (req_if),
    .rsp               (rsp_if),
    .mismatch_count_o  (mismatch_count),
    .answers_waiting_o (answers_waiting)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Offers one request after a random gap and returns once it has been accepted.
  // With no gap, valid simply stays high and only the payload changes, so valid
  // never gets two assignments in one time step.
  task automatic send_request(func_e op, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) begin
      sender_burst = !sender_burst;
    end
    gap = sender_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.func     <= op;
    req_if.ip_addr  <= ip;
    req_if.mac_addr <= mac;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    if (op == FUNC_INSERT) begin
      known_ips.push_back(ip);
      if (known_ips.size() > 20) begin
        void'(known_ips.pop_front());
      end
    end
  endtask

  // Watchdog: any handshake on either channel counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // Response side: before each response it holds ready low for a random number of
  // cycles, with stretches of no stalling at all. Once in the run it holds off for
  // a long stretch while the sender keeps offering, so the block backs up and
  // stops accepting requests.
  initial begin
    int unsigned stall;
    int unsigned responses_taken;
    rsp_if.ready    <= 1'b0;
    responses_taken = 0;
    receiver_burst  = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        receiver_burst = !receiver_burst;
      end
      if (responses_taken == LONG_HOLD_AT) begin
        stall = LONG_HOLD_CYCLES;
      end else begin
        stall = receiver_burst ? 0 : $urandom_range(0, 14);
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
      responses_taken++;
    end
  end

  // Request side: reset, a directed sequence, then the random mix, then the verdict.
  initial begin
    int unsigned pick;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    req_if.valid    <= 1'b0;
    req_if.func     <= FUNC_LOOKUP;
    req_if.ip_addr  <= '0;
    req_if.mac_addr <= '0;
    idle_cycles     = 0;
    sender_burst    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A lookup in an empty table must miss, since no entry is valid yet.
    send_request(FUNC_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    // Extremes of both fields, then lookups that hit them.
    send_request(FUNC_INSERT, 32'h0000_0000, 48'h0000_0000_0000);
    send_request(FUNC_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_request(FUNC_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000);
    send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000);
    // The same address stored twice: the copy at the lower index must win.
    send_request(FUNC_INSERT, 32'hC0A8_0001, 48'h0000_0000_00A1);
    send_request(FUNC_INSERT, 32'hC0A8_0001, 48'h0000_0000_00B2);
    send_request(FUNC_LOOKUP, 32'hC0A8_0001, 48'h5555_5555_5555);
    // A plain miss, with the ignored MAC field set to ones.
    send_request(FUNC_LOOKUP, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF);
    // Fill the remaining entries so that the pointer wraps and the table is full.
    for (int n = 4; n < int'(ENTRIES); n++) begin
      send_request(FUNC_INSERT, 32'h0A00_0100 + n, {16'hAAAA, 32'(n)});
    end
    // Every entry is now valid; entry zero still holds the all-zero address.
    send_request(FUNC_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000);
    // The next insert replaces the oldest entry, so that address then misses.
    send_request(FUNC_INSERT, 32'h8000_0000, 48'h8000_0000_0001);
    send_request(FUNC_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000);
    send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000);

    // Random mix: inserts of fresh or repeated addresses, and lookups that mostly
    // aim at recent inserts so that hits, misses and replacements all occur.
    for (int n = 0; n < int'(RANDOM_REQUESTS); n++) begin
      pick = $urandom_range(0, 99);
      mac  = {16'($urandom), 32'($urandom)};
      if (pick < 40) begin
        if (pick < 15 && known_ips.size() > 0) begin
          ip = known_ips[$urandom_range(0, known_ips.size() - 1)];
        end else begin
          ip = $urandom;
        end
        send_request(FUNC_INSERT, ip, mac);
      end else begin
        if (pick < 85 && known_ips.size() > 0) begin
          ip = known_ips[$urandom_range(0, known_ips.size() - 1)];
        end else begin
          ip = $urandom;
        end
        send_request(FUNC_LOOKUP, ip, mac);
      end
    end
    req_if.valid <= 1'b0;

    // Drain: the waiting count is registered, so let it take in the last request
    // first; then every response must arrive, then allow one lookup's worth of
    // quiet cycles.
    @(posedge clk_i);
    while (answers_waiting != 0) @(posedge clk_i);
    repeat (ENTRIES + 4) @(posedge clk_i);
    if (mismatch_count == 0 && answers_waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
